@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define MLFQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define MLFQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`MLFQ_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/core/mlfq_pkg.sv @@
// Shared types, codes and defaults for the feedback queue scheduler.
// No dependencies; compiled first.
package mlfq_pkg;

	localparam int Q1_DEPTH_DEF = 10;
	localparam int Q2_DEPTH_DEF = 20;
	localparam int Q3_DEPTH_DEF = 30;
	localparam int NUM_QUEUES   = 3;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_SECOND = CFG_IDX_W'(1);

	localparam logic [15:0] QUANTUM_FIRST_RST  = 16'd8;
	localparam logic [15:0] QUANTUM_SECOND_RST = 16'd16;

	localparam logic REQ_ADMIT = 1'b0;
	localparam logic REQ_SCHED = 1'b1;

	localparam logic COIN_PREFER_ONE = 1'b0;

	localparam logic [1:0] QUEUE_ONE   = 2'd0;
	localparam logic [1:0] QUEUE_TWO   = 2'd1;
	localparam logic [1:0] QUEUE_THREE = 2'd2;

	typedef enum logic [2:0] {
		EV_ADMIT  = 3'd0,
		EV_REFUSE = 3'd1,
		EV_IDLE   = 3'd2,
		EV_DONE   = 3'd3,
		EV_TO_Q2  = 3'd4,
		EV_TO_Q1  = 3'd5,
		EV_TO_Q3  = 3'd6,
		EV_KILL   = 3'd7
	} event_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] burst;
	} entry_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  proc_id;
		logic [15:0] burst;
		logic [3:0]  draw;
		logic        coin;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  served_id;
		logic [1:0]  from_queue;
		logic [31:0] start_time;
		logic [31:0] end_time;
		logic [15:0] left_burst;
		logic        all_empty;
	} rsp_item_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} fifo_stat_t;

endpackage

@@ rtl/core/mlfq_req_if.sv @@
// Request channel: admit or schedule beats into the scheduler.
// Depends on nothing but the clocking of the instantiating level.
interface mlfq_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  proc_id;
	logic [15:0] burst;
	logic [3:0]  draw;
	logic        coin;

	modport source(output valid, req_type, proc_id, burst, draw, coin, input ready);
	modport sink(input valid, req_type, proc_id, burst, draw, coin, output ready);
endinterface

@@ rtl/core/mlfq_rsp_if.sv @@
// Result channel: one event beat per request.
// Depends on nothing but the clocking of the instantiating level.
interface mlfq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  served_id;
	logic [1:0]  from_queue;
	logic [31:0] start_time;
	logic [31:0] end_time;
	logic [15:0] left_burst;
	logic        all_empty;

	modport source(output valid, event_res, served_id, from_queue, start_time, end_time,
		left_burst, all_empty, input ready);
	modport sink(input valid, event_res, served_id, from_queue, start_time, end_time,
		left_burst, all_empty, output ready);
endinterface

@@ rtl/core/mlfq_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on mlfq_pkg for field widths.
interface mlfq_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mlfq_pkg::CFG_IDX_W-1:0]  index;
	logic [mlfq_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/multilevel_feedback_queue_scheduler_unit.sv @@
// Top level of the three-level feedback queue scheduler.
// Depends on mlfq_pkg, the channel interfaces, mlfq_ctrl, mlfq_dpath and mlfq_fifo.
//
// channel  dir   beat contents
// -------  ----  ---------------------------------------------------------
// req      in    req_type, proc_id, burst, draw, coin
// rsp      out   event_res, served_id, from_queue, start_time, end_time,
//                left_burst, all_empty
// cfg      in    index (0 quantum_first, 1 quantum_second), data
//
// For a request, the accept edge latches the beat and the queue heads, whose
// memories have a registered read port; a later edge commits it.
// A result sits in the output register; a new request is taken while it waits,
// and only the commit of that request stalls until the result is taken.
// Reset clears queue pointers, counts and time and loads the default quanta;
// queue memories are not cleared, entries are read only after being written.
// cfg is always ready and applies at its beat edge.
module multilevel_feedback_queue_scheduler_unit #(
	parameter int Q1_DEPTH = mlfq_pkg::Q1_DEPTH_DEF,
	parameter int Q2_DEPTH = mlfq_pkg::Q2_DEPTH_DEF,
	parameter int Q3_DEPTH = mlfq_pkg::Q3_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mlfq_req_if.sink   req,
	mlfq_rsp_if.source rsp,
	mlfq_cfg_if.sink   cfg
);

	mlfq_pkg::cmd_t      cmd;
	mlfq_pkg::req_item_t req_item;
	mlfq_pkg::rsp_item_t rsp_item;

	// request beat packed for the item register
	assign req_item = '{
		req_type: req.req_type,
		proc_id:  req.proc_id,
		burst:    req.burst,
		draw:     req.draw,
		coin:     req.coin
	};

	// quantum writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: accept, commit, result valid
	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	// queues, time counter, quanta and result register
	mlfq_dpath #(
		.Q1_DEPTH(Q1_DEPTH),
		.Q2_DEPTH(Q2_DEPTH),
		.Q3_DEPTH(Q3_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_item  (req_item),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.rsp_item  (rsp_item)
	);

	assign rsp.event_res  = rsp_item.event_res;
	assign rsp.served_id  = rsp_item.served_id;
	assign rsp.from_queue = rsp_item.from_queue;
	assign rsp.start_time = rsp_item.start_time;
	assign rsp.end_time   = rsp_item.end_time;
	assign rsp.left_burst = rsp_item.left_burst;
	assign rsp.all_empty  = rsp_item.all_empty;

endmodule

@@ rtl/core/mlfq_fifo.sv @@
// Circular queue of process entries with a registered head read.
// Depends on mlfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlfq_fifo #(
	parameter int DEPTH = mlfq_pkg::Q1_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 pop,
	input  mlfq_pkg::entry_t     wr_data,
	output mlfq_pkg::entry_t     rd_data,
	output mlfq_pkg::fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mlfq_pkg::entry_t mem [DEPTH];
	mlfq_pkg::entry_t rd_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [AW:0]   tail_sum;
	logic [AW:0]   tail_wrap;
	logic [AW-1:0] tail;

	assign tail_sum  = {1'b0, head_q} + (AW+1)'(cnt_q);
	assign tail_wrap = (tail_sum >= (AW+1)'(DEPTH)) ? tail_sum - (AW+1)'(DEPTH) : tail_sum;
	assign tail      = tail_wrap[AW-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail] <= wr_data;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rd_data     = rd_q;
	assign stat.empty  = (cnt_q == '0);
	assign stat.full   = (cnt_q == CW'(DEPTH));
	assign stat.single = (cnt_q == CW'(1));

	`MLFQ_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && stat.full, "push into full queue")
	`MLFQ_ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && stat.empty, "pop from empty queue")

endmodule

@@ rtl/core/mlfq_dpath.sv @@
// Scheduler datapath: item register, three queues, time counter, quanta, result register.
// Depends on mlfq_pkg and mlfq_fifo.
module mlfq_dpath #(
	parameter int Q1_DEPTH = mlfq_pkg::Q1_DEPTH_DEF,
	parameter int Q2_DEPTH = mlfq_pkg::Q2_DEPTH_DEF,
	parameter int Q3_DEPTH = mlfq_pkg::Q3_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlfq_pkg::cmd_t                  cmd,
	input  mlfq_pkg::req_item_t             req_item,
	input  logic                            cfg_we,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_data,
	output mlfq_pkg::rsp_item_t             rsp_item
);

	mlfq_pkg::req_item_t  item_q;
	mlfq_pkg::rsp_item_t  rsp_q;
	logic [31:0]          time_q;
	logic [15:0]          quantum_first_q;
	logic [15:0]          quantum_second_q;

	mlfq_pkg::fifo_stat_t stat [mlfq_pkg::NUM_QUEUES];
	mlfq_pkg::entry_t     head [mlfq_pkg::NUM_QUEUES];
	mlfq_pkg::entry_t     push_data;
	mlfq_pkg::entry_t     sel_e;
	logic [2:0]           push_v;
	logic [2:0]           pop_v;
	logic [2:0]           left_empty;

	logic [1:0]           qsel;
	logic                 qvalid;
	logic [15:0]          quant;
	mlfq_pkg::event_t     ev;
	logic [7:0]           sid;
	logic [1:0]           fq;
	logic [15:0]          left;
	logic [31:0]          t_end;

	always_comb begin
		qsel   = mlfq_pkg::QUEUE_ONE;
		qvalid = 1'b0;
		case (item_q.draw) inside
			[4'd1:4'd5]:  begin qsel = mlfq_pkg::QUEUE_ONE;   qvalid = 1'b1; end
			[4'd6:4'd8]:  begin qsel = mlfq_pkg::QUEUE_TWO;   qvalid = 1'b1; end
			[4'd9:4'd10]: begin qsel = mlfq_pkg::QUEUE_THREE; qvalid = 1'b1; end
			default:      begin qsel = mlfq_pkg::QUEUE_ONE;   qvalid = 1'b0; end
		endcase
	end

	always_comb begin
		ev     = mlfq_pkg::EV_IDLE;
		sid    = '0;
		fq     = mlfq_pkg::QUEUE_ONE;
		left   = '0;
		t_end  = time_q;
		push_v = '0;
		pop_v  = '0;
		sel_e  = head[qsel];
		quant  = (qsel == mlfq_pkg::QUEUE_ONE) ? quantum_first_q : quantum_second_q;
		if (item_q.req_type == mlfq_pkg::REQ_ADMIT) begin
			sid  = item_q.proc_id;
			left = item_q.burst;
			if (!stat[0].full) begin
				push_v[0] = 1'b1;
				ev        = mlfq_pkg::EV_ADMIT;
			end else begin
				ev = mlfq_pkg::EV_REFUSE;
			end
		end else if (qvalid && !stat[qsel].empty) begin
			pop_v[qsel] = 1'b1;
			sid         = sel_e.id;
			fq          = qsel;
			if (qsel == mlfq_pkg::QUEUE_THREE || sel_e.burst <= quant) begin
				t_end = time_q + 32'(sel_e.burst);
				ev    = mlfq_pkg::EV_DONE;
			end else begin
				t_end = time_q + 32'(quant);
				left  = sel_e.burst - quant;
				if (qsel == mlfq_pkg::QUEUE_ONE) begin
					if (!stat[1].full) begin
						push_v[1] = 1'b1;
						ev        = mlfq_pkg::EV_TO_Q2;
					end else begin
						ev = mlfq_pkg::EV_KILL;
					end
				end else if (item_q.coin == mlfq_pkg::COIN_PREFER_ONE) begin
					if (!stat[0].full) begin
						push_v[0] = 1'b1;
						ev        = mlfq_pkg::EV_TO_Q1;
					end else if (!stat[2].full) begin
						push_v[2] = 1'b1;
						ev        = mlfq_pkg::EV_TO_Q3;
					end else begin
						ev = mlfq_pkg::EV_KILL;
					end
				end else begin
					if (!stat[2].full) begin
						push_v[2] = 1'b1;
						ev        = mlfq_pkg::EV_TO_Q3;
					end else if (!stat[0].full) begin
						push_v[0] = 1'b1;
						ev        = mlfq_pkg::EV_TO_Q1;
					end else begin
						ev = mlfq_pkg::EV_KILL;
					end
				end
			end
		end
		// admit stores the request fields, a move stores the served id and remainder
		push_data = '{id: sid, burst: left};
	end

	// occupancy after this step
	always_comb begin
		for (int i = 0; i < mlfq_pkg::NUM_QUEUES; i++) begin
			left_empty[i] = !push_v[i] && (stat[i].empty || (stat[i].single && pop_v[i]));
		end
	end

	mlfq_fifo #(.DEPTH(Q1_DEPTH)) u_q1 (
		.clk(clk), .arst_n(arst_n),
		.push(cmd.commit && push_v[0]), .pop(cmd.commit && pop_v[0]),
		.wr_data(push_data), .rd_data(head[0]), .stat(stat[0])
	);

	mlfq_fifo #(.DEPTH(Q2_DEPTH)) u_q2 (
		.clk(clk), .arst_n(arst_n),
		.push(cmd.commit && push_v[1]), .pop(cmd.commit && pop_v[1]),
		.wr_data(push_data), .rd_data(head[1]), .stat(stat[1])
	);

	mlfq_fifo #(.DEPTH(Q3_DEPTH)) u_q3 (
		.clk(clk), .arst_n(arst_n),
		.push(cmd.commit && push_v[2]), .pop(cmd.commit && pop_v[2]),
		.wr_data(push_data), .rd_data(head[2]), .stat(stat[2])
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_item;
		end
		if (cmd.commit) begin
			rsp_q.event_res  <= ev;
			rsp_q.served_id  <= sid;
			rsp_q.from_queue <= fq;
			rsp_q.start_time <= time_q;
			rsp_q.end_time   <= t_end;
			rsp_q.left_burst <= left;
			rsp_q.all_empty  <= &left_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q           <= '0;
			quantum_first_q  <= mlfq_pkg::QUANTUM_FIRST_RST;
			quantum_second_q <= mlfq_pkg::QUANTUM_SECOND_RST;
		end else begin
			if (cmd.commit) begin
				time_q <= t_end;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mlfq_pkg::CFG_QUANTUM_FIRST:  quantum_first_q  <= cfg_data;
					mlfq_pkg::CFG_QUANTUM_SECOND: quantum_second_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign rsp_item = rsp_q;

endmodule

@@ rtl/core/mlfq_ctrl.sv @@
// Scheduler controller: two-state sequencer and result valid flag.
// Depends on mlfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlfq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           rsp_ready,
	output logic           req_ready,
	output logic           rsp_valid,
	output mlfq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   commit;

	// EXEC may finish once the result register is empty or draining this cycle
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_EXEC;
			ST_EXEC: if (commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = commit;
	assign rsp_valid   = rsp_valid_q;

	`MLFQ_ASSERT(a_commit_gives_valid, clk, arst_n, cmd.commit |=> rsp_valid, "result lost")
	`MLFQ_ASSERT(a_capture_blocks, clk, arst_n, cmd.capture |=> !req_ready, "accepted while busy")
	`MLFQ_ASSERT(a_commit_frees, clk, arst_n, cmd.commit |=> req_ready, "not idle after commit")

endmodule

@@ tb/multilevel_feedback_queue_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the three-level feedback queue scheduler unit.
// Depends on mlfq_pkg, the req/rsp/cfg channel interfaces and the scheduler RTL.
module multilevel_feedback_queue_scheduler_unit_tb;

	localparam int LONG_HOLD     = 150;    // receiver stall used to back the block up
	localparam int SETTLE_CYCLES = 6;      // margin before cfg writes once all results are taken
	localparam int MAX_REPORTS   = 30;
	localparam int SLOT_MAX      = 64;
	localparam int DRAW_Q1_LO    = 1;
	localparam int DRAW_Q1_HI    = 5;
	localparam int DRAW_Q2_HI    = 8;
	localparam int DRAW_Q3_HI    = 10;

	// queue codes as plain ints for the mirror's indexing
	localparam int QUEUE_ONE_IDX   = int'(mlfq_pkg::QUEUE_ONE);
	localparam int QUEUE_TWO_IDX   = int'(mlfq_pkg::QUEUE_TWO);
	localparam int QUEUE_THREE_IDX = int'(mlfq_pkg::QUEUE_THREE);

	// traffic mixes for the random part
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

	logic clk;
	logic arst_n;

	mlfq_req_if req();
	mlfq_rsp_if rsp();
	mlfq_cfg_if cfg();

	multilevel_feedback_queue_scheduler_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	// ---------------------------------------------------------------------
	// Scheduler mirror: three circular queues, the time counter and quanta.
	// ---------------------------------------------------------------------
	mlfq_pkg::entry_t slots [mlfq_pkg::NUM_QUEUES][SLOT_MAX];
	int               head [mlfq_pkg::NUM_QUEUES];
	int               fill [mlfq_pkg::NUM_QUEUES];
	logic [31:0]      clock_now;
	logic [15:0]      quantum_one;
	logic [15:0]      quantum_two;

	mlfq_pkg::req_item_t req_backlog [$];     // beats waiting for the driver
	mlfq_pkg::rsp_item_t events_due [$];      // predicted results, oldest first
	int        mismatches;
	int        results_seen;
	bit        req_took;            // handshake seen at the last rising edge
	bit        rsp_took;
	int        send_wait, send_calm;
	int        recv_wait, recv_calm;
	int        hold_left;
	int        hold_asked, hold_served;
	int        burst_cap;

	function automatic int depth_of(int q);
		case (q)
			QUEUE_ONE_IDX: return mlfq_pkg::Q1_DEPTH_DEF;
			QUEUE_TWO_IDX: return mlfq_pkg::Q2_DEPTH_DEF;
			default:       return mlfq_pkg::Q3_DEPTH_DEF;
		endcase
	endfunction

	function automatic void push_entry(int q, logic [7:0] id, logic [15:0] left);
		mlfq_pkg::entry_t e;
		e.id = id;
		e.burst = left;
		slots[q][(head[q] + fill[q]) % depth_of(q)] = e;
		fill[q]++;
	endfunction

	// Works out the event for one accepted beat and advances the mirror.
	function automatic mlfq_pkg::rsp_item_t next_event(mlfq_pkg::req_item_t it);
		mlfq_pkg::rsp_item_t r;
		mlfq_pkg::entry_t    e;
		logic [15:0]         slice;
		int                  q;
		int                  dest;
		r = '0;
		r.event_res = mlfq_pkg::EV_IDLE;
		r.start_time = clock_now;
		q = -1;
		if (it.req_type == mlfq_pkg::REQ_ADMIT) begin
			r.served_id = it.proc_id;
			r.left_burst = it.burst;
			if (fill[QUEUE_ONE_IDX] < depth_of(QUEUE_ONE_IDX)) begin
				push_entry(QUEUE_ONE_IDX, it.proc_id, it.burst);
				r.event_res = mlfq_pkg::EV_ADMIT;
			end else begin
				r.event_res = mlfq_pkg::EV_REFUSE;
			end
		end else if (it.draw >= DRAW_Q1_LO && it.draw <= DRAW_Q1_HI) begin
			q = QUEUE_ONE_IDX;
		end else if (it.draw > DRAW_Q1_HI && it.draw <= DRAW_Q2_HI) begin
			q = QUEUE_TWO_IDX;
		end else if (it.draw > DRAW_Q2_HI && it.draw <= DRAW_Q3_HI) begin
			q = QUEUE_THREE_IDX;
		end
		// out-of-range draw or empty pick stays idle
		if (q >= 0 && fill[q] != 0) begin
			e = slots[q][head[q]];
			head[q] = (head[q] + 1) % depth_of(q);
			fill[q]--;
			slice = (q == QUEUE_ONE_IDX) ? quantum_one : quantum_two;
			r.served_id = e.id;
			r.from_queue = q[1:0];
			if (q == QUEUE_THREE_IDX || e.burst <= slice) begin
				clock_now += 32'(e.burst);
				r.event_res = mlfq_pkg::EV_DONE;
			end else begin
				clock_now += 32'(slice);
				r.left_burst = e.burst - slice;
				if (q == QUEUE_ONE_IDX) begin
					dest = QUEUE_TWO_IDX;
				end else begin
					// coin picks the first choice, the other queue is the fallback
					dest = (it.coin == mlfq_pkg::COIN_PREFER_ONE) ? QUEUE_ONE_IDX
						: QUEUE_THREE_IDX;
					if (fill[dest] >= depth_of(dest))
						dest = (dest == QUEUE_ONE_IDX) ? QUEUE_THREE_IDX : QUEUE_ONE_IDX;
				end
				if (fill[dest] < depth_of(dest)) begin
					push_entry(dest, e.id, r.left_burst);
					case (dest)
						QUEUE_ONE_IDX: r.event_res = mlfq_pkg::EV_TO_Q1;
						QUEUE_TWO_IDX: r.event_res = mlfq_pkg::EV_TO_Q2;
						default:       r.event_res = mlfq_pkg::EV_TO_Q3;
					endcase
				end else begin
					r.event_res = mlfq_pkg::EV_KILL;
				end
			end
		end
		r.end_time = clock_now;
		r.all_empty = (fill[QUEUE_ONE_IDX] == 0 && fill[QUEUE_TWO_IDX] == 0 &&
			fill[QUEUE_THREE_IDX] == 0);
		return r;
	endfunction

	// Wait before the next beat: mostly a random gap, with calm stretches of no wait.
	function automatic int pick_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	task automatic report_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic add_admit(logic [7:0] id, logic [15:0] b);
		mlfq_pkg::req_item_t it;
		it = '0;
		it.req_type = mlfq_pkg::REQ_ADMIT;
		it.proc_id = id;
		it.burst = b;
		req_backlog.push_back(it);
	endtask

	task automatic add_sched(logic [3:0] d, logic c);
		mlfq_pkg::req_item_t it;
		it = '0;
		it.req_type = mlfq_pkg::REQ_SCHED;
		it.draw = d;
		it.coin = c;
		req_backlog.push_back(it);
	endtask

	// Random beats. FILL admits a lot and never serves queue three, so the
	// queues back up into refusals and kills; DRAIN empties them again.
	task automatic add_random(int count, mix_t mix);
		mlfq_pkg::req_item_t it;
		int                  admit_pct;
		admit_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 5 : 40;
		repeat (count) begin
			it.req_type = ($urandom_range(0, 99) < admit_pct) ? mlfq_pkg::REQ_ADMIT
				: mlfq_pkg::REQ_SCHED;
			it.proc_id = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 15))
				0:       it.burst = 16'd0;
				1:       it.burst = 16'hFFFF;
				2:       it.burst = 16'($urandom_range(0, 65535));
				default: it.burst = 16'($urandom_range(1, burst_cap));
			endcase
			case (mix)
				MIX_FILL:  it.draw = 4'($urandom_range(DRAW_Q1_LO, DRAW_Q2_HI));
				MIX_DRAIN: it.draw = 4'($urandom_range(DRAW_Q1_LO, DRAW_Q3_HI));
				default:   it.draw = 4'($urandom_range(0, 15));
			endcase
			it.coin = (mix == MIX_FILL) ? ($urandom_range(0, 4) != 0)
				: 1'($urandom_range(0, 1));
			req_backlog.push_back(it);
		end
	endtask

	// Sender stops until every predicted result has been taken.
	task automatic settle();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || req.valid || events_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quantum(logic [mlfq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		do
			@(posedge clk);
		while (!cfg.ready);
		if (idx == mlfq_pkg::CFG_QUANTUM_FIRST)
			quantum_one = value;
		else
			quantum_two = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// One quantum setting, then random chunks of mixed traffic. With squeeze
	// set, halfway through the sender pauses for a full drain, then the
	// receiver stalls while a fill burst is offered, so the input backs up.
	task automatic run_phase(logic [15:0] first, logic [15:0] second, int budget, int cap,
		bit squeeze);
		int issued;
		int n;
		write_quantum(mlfq_pkg::CFG_QUANTUM_FIRST, first);
		write_quantum(mlfq_pkg::CFG_QUANTUM_SECOND, second);
		burst_cap = cap;
		issued = 0;
		while (issued < budget) begin
			n = $urandom_range(30, 50);
			add_random(n, mix_t'($urandom_range(0, 2)));
			issued += n;
			if (squeeze && 2 * issued >= budget) begin
				settle();
				hold_asked++;
				add_random(40, MIX_FILL);
				issued += 40;
				squeeze = 0;
			end
		end
		settle();
	endtask

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Driver: presents the backlog on req, one beat at a time, at falling edges.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		mlfq_pkg::req_item_t nxt;
		if (arst_n && (!req.valid || req_took)) begin
			if (req_took)
				send_wait = pick_gap(send_calm);
			if (send_wait > 0 || req_backlog.size() == 0) begin
				if (send_wait > 0)
					send_wait--;
				req.valid <= 1'b0;
			end else begin
				nxt = req_backlog.pop_front();
				req.valid <= 1'b1;
				req.req_type <= nxt.req_type;
				req.proc_id <= nxt.proc_id;
				req.burst <= nxt.burst;
				req.draw <= nxt.draw;
				req.coin <= nxt.coin;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random ready gaps after each taken result, plus the long hold
	// that the stimulus asks for by bumping hold_asked.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_took)
				recv_wait = pick_gap(recv_calm);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks taken results against the oldest prediction, then
	// predicts the request beat taken at the same edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		mlfq_pkg::rsp_item_t got;
		mlfq_pkg::rsp_item_t want;
		req_took = arst_n && req.valid && req.ready;
		rsp_took = arst_n && rsp.valid && rsp.ready;
		if (rsp_took) begin
			results_seen++;
			got = {rsp.event_res, rsp.served_id, rsp.from_queue, rsp.start_time,
				rsp.end_time, rsp.left_burst, rsp.all_empty};
			if (events_due.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = events_due.pop_front();
				check_field("event_res", 32'(got.event_res), 32'(want.event_res));
				check_field("served_id", 32'(got.served_id), 32'(want.served_id));
				check_field("from_queue", 32'(got.from_queue), 32'(want.from_queue));
				check_field("start_time", got.start_time, want.start_time);
				check_field("end_time", got.end_time, want.end_time);
				check_field("left_burst", 32'(got.left_burst), 32'(want.left_burst));
				check_field("all_empty", 32'(got.all_empty), 32'(want.all_empty));
			end
		end
		if (req_took)
			events_due.push_back(next_event({req.req_type, req.proc_id, req.burst,
				req.draw, req.coin}));
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [15:0] qa;
		logic [15:0] qb;
		bit          squeeze;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = mlfq_pkg::REQ_ADMIT;
		req.proc_id = '0;
		req.burst = '0;
		req.draw = '0;
		req.coin = 1'b0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = mlfq_pkg::CFG_QUANTUM_FIRST;
		cfg.data = '0;
		for (int q = 0; q < mlfq_pkg::NUM_QUEUES; q++) begin
			head[q] = 0;
			fill[q] = 0;
		end
		clock_now = '0;
		quantum_one = mlfq_pkg::QUANTUM_FIRST_RST;
		quantum_two = mlfq_pkg::QUANTUM_SECOND_RST;
		mismatches = 0;
		results_seen = 0;
		send_wait = 0;
		send_calm = 0;
		recv_wait = 0;
		recv_calm = 0;
		hold_left = 0;
		hold_asked = 0;
		hold_served = 0;
		burst_cap = 48;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset quanta (8 / 16).
		// idle: out-of-range draws, then each empty queue
		add_sched(4'd0, 1'b0);
		add_sched(4'd15, 1'b1);
		add_sched(4'd11, 1'b0);
		add_sched(4'd1, 1'b1);
		add_sched(4'd6, 1'b0);
		add_sched(4'd9, 1'b1);
		// admits at the field extremes, zero burst among them
		add_admit(8'h00, 16'd0);
		add_admit(8'hFF, 16'hFFFF);
		add_admit(8'h5A, 16'd20);
		add_admit(8'hA5, 16'd1);
		add_admit(8'h11, 16'd40);
		add_sched(4'd1, 1'b0);      // zero burst finishes, time unchanged
		add_sched(4'd5, 1'b0);      // long burst demoted to queue two
		add_sched(4'd2, 1'b1);      // demoted
		add_sched(4'd3, 1'b0);      // fits in one slice
		add_sched(4'd4, 1'b1);      // demoted
		add_sched(4'd6, 1'b1);      // queue two remainder, coin prefers queue three
		add_sched(4'd8, 1'b0);      // finishes from queue two
		add_sched(4'd7, 1'b0);      // remainder back to queue one
		add_sched(4'd10, 1'b1);     // queue three runs to completion
		add_sched(4'd1, 1'b0);      // demoted again
		add_sched(4'd6, 1'b1);      // finishes, all queues empty
		add_sched(4'd9, 1'b0);      // queue three now empty
		settle();

		// Extreme quanta, including the zero-length slice.
		run_phase(16'd1, 16'hFFFF, 100, 48, 1'b0);
		run_phase(16'hFFFF, 16'd1, 100, 48, 1'b0);
		run_phase(16'd0, 16'd0, 60, 48, 1'b0);

		// Random small quanta; the first of these carries the stall pressure.
		squeeze = 1'b1;
		repeat (3) begin
			qa = 16'($urandom_range(1, 24));
			qb = 16'($urandom_range(1, 24));
			run_phase(qa, qb, 150, 3 * ((qa > qb) ? qa : qb) + 4, squeeze);
			squeeze = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("multilevel_feedback_queue_scheduler_unit test passed");
		end else begin
			$display("multilevel_feedback_queue_scheduler_unit test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("multilevel_feedback_queue_scheduler_unit test failed");
		$finish;
	end

endmodule
